[sv/rcr_pkg.sv]
// ----------------------------------------------------------------------------
// rcr_pkg: shared types and constants for RSSI calibration and ranging
// Node table sizes, status codes, controller commands and the 2^(2^-k) table.
// ----------------------------------------------------------------------------
package rcr_pkg;

  localparam int NODE_COUNT  = 26;
  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W       = $clog2(NODE_COUNT);
  localparam int CNT_W       = 7;
  localparam int SUM_W       = 14;
  localparam int SQ_W        = 21;
  localparam int DIVN_W      = 51;
  localparam int DIVD_W      = 33;
  localparam int DCNT_W      = $clog2(DIVN_W);
  localparam int EXP_STEPS   = 24;
  localparam logic [25:0] LOG2_10_Q24 = 26'd55732705;
  localparam logic [7:0]  LETTER_A    = 8'd65;
  localparam logic [6:0]  THR_MIN     = 7'd2;
  localparam logic [6:0]  THR_MAX     = 7'(MAX_SAMPLES);
  localparam logic [3:0]  PLE_MIN     = 4'd1;
  localparam logic [3:0]  PLE_MAX     = 4'd8;

  typedef enum logic [2:0] {
    ST_IGNORED      = 3'd0,
    ST_STORED       = 3'd1,
    ST_CAL_DONE     = 3'd2,
    ST_ESTIMATE     = 3'd3,
    ST_EST_ZERO_VAR = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_CAL_COUNT = 1'b0,
    CFG_PATH_LOSS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic m1;
    logic m2;
    logic m3;
    logic div_step;
    logic mchk;
    logic sqrt_step;
    logic ucalc;
    logic exp_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic beacon;
    logic calibrated;
    logic zero_var;
    logic div_last;
    logic sqrt_last;
    logic exp_last;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] x;
    res = '0;
    b   = 64'h1 << 62;
    x   = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [EXP_STEPS:0][31:0] build_exp_table();
    logic [EXP_STEPS:0][31:0] tab;
    logic [63:0] c;
    c      = 64'h1 << 31;
    tab[0] = c[31:0];
    for (int k = 1; k <= EXP_STEPS; k++) begin
      c      = isqrt_const(c << 30);
      tab[k] = c[31:0];
    end
    return tab;
  endfunction

  localparam logic [EXP_STEPS:0][31:0] EXP_TABLE = build_exp_table();

endpackage

[sv/rcr_ctrl.sv]
// ----------------------------------------------------------------------------
// rcr_ctrl: sequencing controller
// Steps one packet through table access, the divider, square root and power.
// ----------------------------------------------------------------------------
module rcr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  rcr_pkg::sts_t st,
  output rcr_pkg::cmd_t cmd
);
  import rcr_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_LOAD   = 12'b000000000010,
    S_M1     = 12'b000000000100,
    S_M2     = 12'b000000001000,
    S_M3     = 12'b000000010000,
    S_DIVM   = 12'b000000100000,
    S_MCHK   = 12'b000001000000,
    S_SQRT   = 12'b000010000000,
    S_DIVR   = 12'b000100000000,
    S_UCALC  = 12'b001000000000,
    S_EXP    = 12'b010000000000,
    S_FINISH = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = (st.beacon && st.calibrated) ? S_M1 : S_FINISH;
      end
      S_M1: begin
        cmd.m1     = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.m2     = 1'b1;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.m3     = 1'b1;
        state_next = st.zero_var ? S_DIVR : S_DIVM;
      end
      S_DIVM: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_MCHK;
      end
      S_MCHK: begin
        cmd.mchk   = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (st.sqrt_last) state_next = S_DIVR;
      end
      S_DIVR: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_UCALC;
      end
      S_UCALC: begin
        cmd.ucalc  = 1'b1;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.exp_step = 1'b1;
        if (st.exp_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = st.out_free;
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

endmodule

[sv/rcr_dp.sv]
// ----------------------------------------------------------------------------
// rcr_dp: datapath
// Node tables, statistics, bit-serial divider, square root, power of two unit
// and the result register.
// ----------------------------------------------------------------------------
module rcr_dp (
  input  logic          clk,
  input  logic          rst,
  input  rcr_pkg::cmd_t cmd,
  output rcr_pkg::sts_t st,
  input  logic [7:0]    payload_length,
  input  logic [7:0]    first_byte,
  input  logic signed [7:0] rssi,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [6:0]    cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic [4:0]    node_index,
  output logic [6:0]    sample_count,
  output logic [15:0]   mahalanobis_q8_8,
  output logic [23:0]   range_q16_8
);
  import rcr_pkg::*;

  logic [6:0] calibration_count;
  logic [3:0] path_loss_exponent;

  logic [CNT_W-1:0]        count_tab [NODE_COUNT];
  logic signed [SUM_W-1:0] sum_tab   [NODE_COUNT];
  logic [SQ_W-1:0]         sq_tab    [NODE_COUNT];

  logic [IDX_W-1:0]  idx;
  logic              beacon;
  logic signed [7:0] r;
  logic [6:0]        thr;
  logic [3:0]        ple;
  logic [7:0]        byte_off;

  logic [CNT_W-1:0]        n;
  logic signed [SUM_W-1:0] s;
  logic signed [14:0]      nr;
  logic [27:0]             nq;
  logic [27:0]             ss;
  logic [14:0]             ad;
  logic                    prod_neg;
  logic [26:0]             spread_u;
  logic                    zero_var;
  logic [29:0]             ad2;
  logic [DIVD_W-1:0]       den_m;
  logic [40:0]             prod_mag;
  logic [14:0]             den_r;

  logic [DIVN_W-1:0] div_q;
  logic [DIVD_W:0]   div_rem;
  logic [DIVD_W-1:0] div_den;
  logic [DCNT_W-1:0] div_cnt;

  logic        msat;
  logic [31:0] rad;
  logic [15:0] root;
  logic [17:0] sq_rem;
  logic [3:0]  sq_cnt;

  logic [23:0] frac;
  logic [4:0]  ip;
  logic        u_neg;
  logic        u_sat;
  logic [30:0] acc;
  logic [4:0]  ek;

  logic [2:0]  res_status;
  logic [4:0]  res_idx;
  logic [6:0]  res_count;
  logic [15:0] res_mahal;
  logic        res_est;

  // combinational helpers
  logic [CNT_W-1:0]        n_c;
  logic signed [SUM_W-1:0] s_c;
  logic [SQ_W-1:0]         q_c;
  logic [CNT_W-1:0]        n_inc;
  logic signed [15:0]      dev;
  logic signed [28:0]      spread;
  logic [DIVD_W:0]         div_sh;
  logic                    div_ge;
  logic [17:0]             sq_sh;
  logic [17:0]             sq_trial;
  logic                    sq_ge;
  logic [37:0]             t_mag;
  logic signed [52:0]      u;
  logic [62:0]             exp_prod;
  logic [30:0]             acc_sh;
  logic [6:0]              thr_in;
  logic [3:0]              ple_in;

  assign byte_off = first_byte - LETTER_A;
  assign thr_in   = (calibration_count < THR_MIN) ? THR_MIN :
                    (calibration_count > THR_MAX) ? THR_MAX : calibration_count;
  assign ple_in   = (path_loss_exponent < PLE_MIN) ? PLE_MIN :
                    (path_loss_exponent > PLE_MAX) ? PLE_MAX : path_loss_exponent;

  assign n_c   = count_tab[idx];
  assign s_c   = sum_tab[idx];
  assign q_c   = sq_tab[idx];
  assign n_inc = n_c + 7'd1;

  assign dev    = 16'(nr) - 16'(s);
  assign spread = $signed({1'b0, nq}) - $signed({1'b0, ss});

  assign div_sh = {div_rem[DIVD_W-1:0], div_q[DIVN_W-1]};
  assign div_ge = (div_sh >= {1'b0, div_den});

  assign sq_sh    = {sq_rem[15:0], rad[31:30]};
  assign sq_trial = {root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  assign t_mag    = 38'(div_q) + 38'(prod_neg && (div_rem != '0));
  assign u        = prod_neg ? (53'sd134217728 - $signed({15'd0, t_mag}))
                             : (53'sd134217728 + $signed({15'd0, t_mag}));
  assign exp_prod = acc * EXP_TABLE[ek];
  assign acc_sh   = acc >> (5'd30 - ip);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      calibration_count  <= 7'd50;
      path_loss_exponent <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CAL_COUNT: calibration_count  <= cfg_data;
        CFG_PATH_LOSS: path_loss_exponent <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // node tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        count_tab[i] <= '0;
        sum_tab[i]   <= '0;
        sq_tab[i]    <= '0;
      end
    end else if (cmd.load && beacon && (n_c < thr)) begin
      count_tab[idx] <= n_inc;
      sum_tab[idx]   <= s_c + SUM_W'(r);
      sq_tab[idx]    <= q_c + SQ_W'(unsigned'(16'(r * r)));
    end
  end

  // packet capture and statistics
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      beacon <= (payload_length == 8'd1) && (byte_off < 8'(NODE_COUNT));
      idx    <= IDX_W'(byte_off);
      r      <= rssi;
      thr    <= thr_in;
      ple    <= ple_in;
    end
    if (cmd.load) begin
      n  <= n_c;
      s  <= s_c;
      nr <= 15'($signed({1'b0, n_c}) * r);
      nq <= 28'(n_c * q_c);
      ss <= 28'(unsigned'(28'(s_c * s_c)));
    end
    if (cmd.m1) begin
      ad       <= 15'(dev < 0 ? -dev : dev);
      prod_neg <= (dev > 0);
      zero_var <= (spread <= 0);
      spread_u <= spread[26:0];
    end
    if (cmd.m2) begin
      ad2      <= ad * ad;
      den_m    <= DIVD_W'(n * spread_u);
      prod_mag <= 41'(ad * LOG2_10_Q24);
      den_r    <= 15'((ple * n) * 4'd10);
    end
  end

  // shared restoring divider
  always_ff @(posedge clk) begin
    if (cmd.m3 && !zero_var) begin
      div_q   <= DIVN_W'(ad2 * (n - 7'd1)) << 16;
      div_den <= den_m;
      div_rem <= '0;
      div_cnt <= '0;
    end else if ((cmd.m3 && zero_var) || cmd.mchk) begin
      div_q   <= DIVN_W'(prod_mag);
      div_den <= DIVD_W'(den_r);
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? (div_sh - {1'b0, div_den}) : div_sh;
      div_q   <= {div_q[DIVN_W-2:0], div_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // square root, two radicand bits a step
  always_ff @(posedge clk) begin
    if (cmd.mchk) begin
      msat   <= (div_q[DIVN_W-1:32] != '0);
      rad    <= div_q[31:0];
      root   <= '0;
      sq_rem <= '0;
      sq_cnt <= '0;
    end else if (cmd.sqrt_step) begin
      sq_rem <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
      root   <= {root[14:0], sq_ge};
      rad    <= {rad[29:0], 2'b00};
      sq_cnt <= sq_cnt + 4'd1;
    end
  end

  // power of two: integer part by shift, fraction by constant products
  always_ff @(posedge clk) begin
    if (cmd.ucalc) begin
      u_neg <= u[52];
      u_sat <= !u[52] && (u[51:24] >= 28'd24);
      ip    <= u[28:24];
      frac  <= u[23:0];
      acc   <= 31'h4000_0000;
      ek    <= 5'd1;
    end else if (cmd.exp_step) begin
      if (frac[5'(EXP_STEPS) - ek]) acc <= exp_prod[60:30];
      ek <= ek + 5'd1;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_mahal <= '0;
      res_est   <= 1'b0;
      if (!beacon) begin
        res_status <= ST_IGNORED;
        res_idx    <= '0;
        res_count  <= '0;
      end else if (n_c < thr) begin
        res_status <= (n_inc >= thr) ? ST_CAL_DONE : ST_STORED;
        res_idx    <= 5'(idx);
        res_count  <= n_inc;
      end else begin
        res_status <= ST_ESTIMATE;
        res_idx    <= 5'(idx);
        res_count  <= n_c;
        res_est    <= 1'b1;
      end
    end
    if (cmd.m3 && zero_var) begin
      res_status <= ST_EST_ZERO_VAR;
      res_mahal  <= (ad == '0) ? 16'd0 : 16'hFFFF;
    end
    if (cmd.sqrt_step && (sq_cnt == 4'd15)) begin
      res_mahal <= msat ? 16'hFFFF : {root[14:0], sq_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status           <= res_status;
      node_index       <= res_idx;
      sample_count     <= res_count;
      mahalanobis_q8_8 <= res_mahal;
      range_q16_8      <= (!res_est || u_neg) ? 24'd0 :
                          u_sat ? 24'hFFFFFF : acc_sh[23:0];
    end
  end

  assign st.beacon     = beacon;
  assign st.calibrated = (n_c >= thr);
  assign st.zero_var   = zero_var;
  assign st.div_last   = (div_cnt == DCNT_W'(DIVN_W - 1));
  assign st.sqrt_last  = (sq_cnt == 4'd15);
  assign st.exp_last   = (ek == 5'(EXP_STEPS));
  assign st.out_free   = !out_valid || out_ready;

endmodule

[sv/rssi_calibrate_and_range.sv]
// ----------------------------------------------------------------------------
// rssi_calibrate_and_range: per-node RSSI calibration and range estimation
// One packet in work at a time, set by the 51-step bit-serial divider (run twice
// for an estimate, once for a zero-variance estimate), the 16-step square root
// and the 24-step power unit. A held result stalls the next packet. Reset
// (synchronous): tables cleared, regs 50 and 2.
// ----------------------------------------------------------------------------
module rssi_calibrate_and_range (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // payload_length, first_byte, rssi
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status, node_index, sample_count, mahalanobis_q8_8,
                                 // range_q16_8, zero pad
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import rcr_pkg::*;

  cmd_t        cmd;
  sts_t        st;
  logic [2:0]  status;
  logic [4:0]  node_index;
  logic [6:0]  sample_count;
  logic [15:0] mahalanobis_q8_8;
  logic [23:0] range_q16_8;

  rcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rcr_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .payload_length   (s_tdata[7:0]),
    .first_byte       (s_tdata[15:8]),
    .rssi             (s_tdata[23:16]),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .status           (status),
    .node_index       (node_index),
    .sample_count     (sample_count),
    .mahalanobis_q8_8 (mahalanobis_q8_8),
    .range_q16_8      (range_q16_8)
  );

  assign m_tdata = {1'b0, range_q16_8, mahalanobis_q8_8, sample_count, node_index, status};

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a packet is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (status <= ST_EST_ZERO_VAR))
    else $error("undefined status code");

  a_ignored_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_IGNORED) |-> (m_tdata[54:3] == '0))
    else $error("ignored packet with non-zero fields");

  a_sample_no_estimate: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status == ST_STORED || status == ST_CAL_DONE))
      |-> (mahalanobis_q8_8 == '0 && range_q16_8 == '0))
    else $error("estimate fields set on a calibration sample");

endmodule
